// File: sv/pwc_pkg.sv
// ----------------------------------------------------------------------------
// pwc_pkg
// Shared types, constants and edge-parameter helpers for the window clipper.
// ----------------------------------------------------------------------------
package pwc_pkg;

  localparam int CW = 32;
  localparam int DW = CW + 1;
  localparam int PW = 2 * CW;
  localparam int SW = 2 * CW + 2;
  localparam int IO_W = 32;

  typedef enum logic [1:0] {
    REG_WIN_LEFT,
    REG_WIN_BOTTOM,
    REG_WIN_RIGHT,
    REG_WIN_TOP
  } reg_idx_e;

  typedef enum logic [1:0] {
    CMP_LT,
    CMP_EQ,
    CMP_GT
  } cmp_e;

  typedef enum logic [1:0] {
    PT_FIX,
    PT_IX,
    PT_IY
  } pt_e;

  typedef struct packed {
    logic signed [CW-1:0] left;
    logic signed [CW-1:0] bottom;
    logic signed [CW-1:0] right;
    logic signed [CW-1:0] top;
  } win_t;

  typedef struct packed {
    logic                 pinf;
    logic                 ninf;
    logic signed [DW-1:0] num;
    logic [CW-1:0]        den;
  } tval_t;

  typedef struct packed {
    logic signed [CW-1:0] x1;
    logic signed [CW-1:0] y1;
    logic signed [CW-1:0] x2;
    logic signed [CW-1:0] y2;
    logic signed [CW-1:0] xin;
    logic signed [CW-1:0] xout;
    logic signed [CW-1:0] yin;
    logic signed [CW-1:0] yout;
    logic signed [DW-1:0] dx;
    logic signed [DW-1:0] dy;
    tval_t                tinx;
    tval_t                tiny;
    tval_t                toutx;
    tval_t                touty;
  } edge_t;

  typedef struct packed {
    pt_e                  kind;
    logic signed [CW-1:0] cx;
    logic signed [CW-1:0] cy;
    tval_t                t;
  } slot_t;

  function automatic logic [CW-1:0] mag(logic signed [DW-1:0] v);
    logic signed [DW-1:0] nv;
    nv = -v;
    return (v < 0) ? nv[CW-1:0] : v[CW-1:0];
  endfunction

  function automatic tval_t tmake(logic signed [DW-1:0] n, logic signed [DW-1:0] d,
                                  logic sg_pos);
    tval_t t;
    logic signed [DW-1:0] nd;
    logic signed [DW-1:0] nn;
    nd = -d;
    nn = -n;
    t.pinf = 1'b0;
    t.ninf = 1'b0;
    t.num  = '0;
    t.den  = CW'(1);
    if (d != '0) begin
      if (d < 0) begin
        t.num = nn;
        t.den = nd[CW-1:0];
      end else begin
        t.num = n;
        t.den = d[CW-1:0];
      end
    end else if (n != '0) begin
      if ((n > 0) == sg_pos) t.pinf = 1'b1;
      else t.ninf = 1'b1;
    end
    return t;
  endfunction

  function automatic logic [1:0] rank_inf(tval_t a);
    return a.pinf ? 2'd2 : (a.ninf ? 2'd0 : 2'd1);
  endfunction

  function automatic logic [1:0] rank_sign(logic signed [DW-1:0] v);
    return (v > 0) ? 2'd2 : ((v == '0) ? 2'd1 : 2'd0);
  endfunction

  // pa = |a.num| * b.den, pb = |b.num| * a.den
  function automatic cmp_e tcmp(tval_t a, tval_t b, logic [PW-1:0] pa, logic [PW-1:0] pb);
    logic [1:0] ra;
    logic [1:0] rb;
    cmp_e r;
    if (a.pinf || a.ninf || b.pinf || b.ninf) begin
      ra = rank_inf(a);
      rb = rank_inf(b);
      r = (ra > rb) ? CMP_GT : ((ra < rb) ? CMP_LT : CMP_EQ);
    end else begin
      ra = rank_sign(a.num);
      rb = rank_sign(b.num);
      if (ra != rb) r = (ra > rb) ? CMP_GT : CMP_LT;
      else if (pa == pb) r = CMP_EQ;
      else if (ra != 2'd0) r = (pa > pb) ? CMP_GT : CMP_LT;
      else r = (pa > pb) ? CMP_LT : CMP_GT;
    end
    return r;
  endfunction

  function automatic cmp_e tzero(tval_t a);
    cmp_e r;
    if (a.pinf) r = CMP_GT;
    else if (a.ninf) r = CMP_LT;
    else if (a.num > 0) r = CMP_GT;
    else if (a.num == '0) r = CMP_EQ;
    else r = CMP_LT;
    return r;
  endfunction

  function automatic cmp_e tone(tval_t a);
    logic signed [DW:0] df;
    cmp_e r;
    df = (DW+1)'(a.num) - $signed({2'b00, a.den});
    if (a.pinf) r = CMP_GT;
    else if (a.ninf) r = CMP_LT;
    else if (df > 0) r = CMP_GT;
    else if (df == '0) r = CMP_EQ;
    else r = CMP_LT;
    return r;
  endfunction

endpackage

// File: sv/pwc_vtx_if.sv
// ----------------------------------------------------------------------------
// pwc_vtx_if
// Vertex request channel: valid/ready with one polygon vertex.
// ----------------------------------------------------------------------------
interface pwc_vtx_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] vert_x;
  logic signed [31:0] vert_y;
  logic               prime;

  modport source (output valid, output vert_x, output vert_y, output prime, input ready);
  modport sink (input valid, input vert_x, input vert_y, input prime, output ready);
endinterface

// File: sv/pwc_pt_if.sv
// ----------------------------------------------------------------------------
// pwc_pt_if
// Clipped point channel: valid/ready with one emitted vertex.
// ----------------------------------------------------------------------------
interface pwc_pt_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] out_x;
  logic signed [31:0] out_y;
  logic               run_last;

  modport source (output valid, output out_x, output out_y, output run_last, input ready);
  modport sink (input valid, input out_x, input out_y, input run_last, output ready);
endinterface

// File: sv/pwc_front.sv
// ----------------------------------------------------------------------------
// pwc_front
// Accepts vertices, tracks the previous point and builds the edge parameters.
// ----------------------------------------------------------------------------
module pwc_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  pwc_vtx_if.sink        vtx,
  input  pwc_pkg::win_t  win_i,
  input  logic           full_i,
  output logic           push_o,
  output pwc_pkg::edge_t edge_o
);
  import pwc_pkg::*;

  logic signed [CW-1:0] prev_x_q, prev_x_d;
  logic signed [CW-1:0] prev_y_q, prev_y_d;
  logic signed [CW-1:0] x2, y2;
  logic signed [DW-1:0] dx, dy;
  logic                 sgx, sgy;
  logic                 acc;

  assign vtx.ready = !full_i;
  assign acc       = vtx.valid && !full_i;
  assign push_o    = acc && !vtx.prime;

  assign x2 = $signed(vtx.vert_x[CW-1:0]);
  assign y2 = $signed(vtx.vert_y[CW-1:0]);
  assign dx = DW'(x2) - DW'(prev_x_q);
  assign dy = DW'(y2) - DW'(prev_y_q);
  assign sgx = (dx > 0) || ((dx == '0) && !(prev_x_q > win_i.left));
  assign sgy = (dy > 0) || ((dy == '0) && !(prev_y_q > win_i.bottom));

  always_comb begin
    edge_o.x1    = prev_x_q;
    edge_o.y1    = prev_y_q;
    edge_o.x2    = x2;
    edge_o.y2    = y2;
    edge_o.dx    = dx;
    edge_o.dy    = dy;
    edge_o.xin   = sgx ? win_i.left : win_i.right;
    edge_o.xout  = sgx ? win_i.right : win_i.left;
    edge_o.yin   = sgy ? win_i.bottom : win_i.top;
    edge_o.yout  = sgy ? win_i.top : win_i.bottom;
    edge_o.tinx  = tmake(DW'(edge_o.xin) - DW'(prev_x_q), dx, sgx);
    edge_o.tiny  = tmake(DW'(edge_o.yin) - DW'(prev_y_q), dy, sgy);
    edge_o.toutx = tmake(DW'(edge_o.xout) - DW'(prev_x_q), dx, sgx);
    edge_o.touty = tmake(DW'(edge_o.yout) - DW'(prev_y_q), dy, sgy);
  end

  assign prev_x_d = acc ? x2 : prev_x_q;
  assign prev_y_d = acc ? y2 : prev_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_x_q <= '0;
      prev_y_q <= '0;
    end else begin
      prev_x_q <= prev_x_d;
      prev_y_q <= prev_y_d;
    end
  end

endmodule

// File: sv/pwc_fifo.sv
// ----------------------------------------------------------------------------
// pwc_fifo
// Two-entry edge queue between the front and the back.
// ----------------------------------------------------------------------------
module pwc_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  pwc_pkg::edge_t data_i,
  input  logic           pop_i,
  output logic           full_o,
  output logic           valid_o,
  output pwc_pkg::edge_t data_o
);
  import pwc_pkg::*;

  edge_t      mem_q [2];
  logic       wp_q, wp_d;
  logic       rp_q, rp_d;
  logic [1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign data_o  = mem_q[rp_q];

  always_comb begin
    wp_d  = push_i ? !wp_q : wp_q;
    rp_d  = pop_i ? !rp_q : rp_q;
    cnt_d = cnt_q + 2'(push_i) - 2'(pop_i);
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wp_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

// File: sv/pwc_div.sv
// ----------------------------------------------------------------------------
// pwc_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pwc_div (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [pwc_pkg::PW-1:0]   dividend_i,
  input  logic [pwc_pkg::CW-1:0]   divisor_i,
  output logic                     done_o,
  output logic [pwc_pkg::PW-1:0]   quo_o
);
  import pwc_pkg::*;

  localparam int CNT_W = $clog2(PW);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [CW-1:0]    rem_q, rem_d;
  logic [PW-1:0]    quo_q, quo_d;
  logic [CW-1:0]    dvs_q, dvs_d;
  logic [CW:0]      sh, sub;
  logic             ge;

  assign sh  = {rem_q, quo_q[PW-1]};
  assign ge  = (sh >= {1'b0, dvs_q});
  assign sub = sh - {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = dividend_i;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = ge ? sub[CW-1:0] : sh[CW-1:0];
      quo_d = {quo_q[PW-2:0], ge};
      cnt_d = cnt_q + CNT_W'(1);
      if (cnt_q == CNT_W'(PW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      rem_q  <= '0;
      quo_q  <= '0;
      dvs_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
      rem_q  <= rem_d;
      quo_q  <= quo_d;
      dvs_q  <= dvs_d;
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

// File: sv/pwc_back.sv
// ----------------------------------------------------------------------------
// pwc_back
// Orders the edge parameters, plans up to three points and emits them.
// ----------------------------------------------------------------------------
module pwc_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  input  pwc_pkg::edge_t edge_i,
  output logic           pop_o,
  pwc_pt_if.source       pt
);
  import pwc_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MA,
    S_MB,
    S_CMP,
    S_PLAN,
    S_PT,
    S_IMUL,
    S_DGO,
    S_DIV,
    S_OUT
  } state_e;

  state_e               state_q, state_d;
  edge_t                e_q;
  cmp_e                 c_q [3];
  logic [1:0]           cs_q;
  logic [PW-1:0]        pa_q, pb_q;
  slot_t                slot_q [3];
  logic [2:0]           vld_q;
  logic [1:0]           sel_q;
  logic signed [CW-1:0] res_x_q, res_y_q;
  logic                 ovalid_q;
  logic signed [CW-1:0] ox_q, oy_q;
  logic                 olast_q;

  tval_t                ca, cb, tin1, tin2, tout;
  logic [CW-1:0]        ma, mb;
  logic [PW-1:0]        prod;
  slot_t                cur;
  logic                 is_ix;
  logic signed [CW-1:0] st;
  logic signed [DW-1:0] dl;
  logic                 bypass, neg;
  logic signed [SW-1:0] sum;
  logic                 last;
  logic                 out_free;
  logic                 div_start, div_done;
  logic [PW-1:0]        div_quo;
  slot_t                p_slot [3];
  logic [2:0]           p_vld;
  logic                 mid, inner;

  assign tin1 = (c_q[0] == CMP_LT) ? e_q.tinx : e_q.tiny;
  assign tin2 = (c_q[0] == CMP_LT) ? e_q.tiny : e_q.tinx;
  assign tout = (c_q[1] == CMP_LT) ? e_q.toutx : e_q.touty;

  always_comb begin
    case (cs_q)
      2'd0: begin
        ca = e_q.tinx;
        cb = e_q.tiny;
      end
      2'd1: begin
        ca = e_q.toutx;
        cb = e_q.touty;
      end
      default: begin
        ca = tin2;
        cb = tout;
      end
    endcase
  end

  assign cur    = slot_q[sel_q];
  assign is_ix  = (cur.kind == PT_IX);
  assign st     = is_ix ? e_q.x1 : e_q.y1;
  assign dl     = is_ix ? e_q.dx : e_q.dy;
  assign bypass = (dl == '0) || cur.t.pinf || cur.t.ninf;
  assign neg    = ((cur.t.num < 0) != (dl < 0)) && (cur.t.num != '0);
  assign sum    = neg ? (SW'(st) - SW'(div_quo)) : (SW'(st) + SW'(div_quo));

  always_comb begin
    case (state_q)
      S_MA: begin
        ma = mag(ca.num);
        mb = cb.den;
      end
      S_MB: begin
        ma = mag(cb.num);
        mb = ca.den;
      end
      default: begin
        ma = mag(cur.t.num);
        mb = mag(dl);
      end
    endcase
  end

  assign prod = PW'(ma) * PW'(mb);

  always_comb begin
    case (sel_q)
      2'd0: last = !vld_q[1] && !vld_q[2];
      2'd1: last = !vld_q[2];
      default: last = 1'b1;
    endcase
  end

  always_comb begin
    mid   = (tone(tin1) != CMP_GT) && (tone(tin2) != CMP_GT) &&
            ((tzero(tin2) == CMP_GT) || (tzero(tout) == CMP_GT));
    inner = mid && (c_q[2] != CMP_GT);
    p_vld[0] = (tone(tin1) != CMP_GT) && (tzero(tin1) == CMP_GT);
    p_vld[1] = inner && (tzero(tin2) == CMP_GT);
    p_vld[2] = mid;
    p_slot[0] = '{kind: PT_FIX, cx: e_q.xin, cy: e_q.yin, t: e_q.tinx};
    if (c_q[0] == CMP_GT) p_slot[1] = '{kind: PT_IY, cx: e_q.xin, cy: e_q.yin, t: e_q.tinx};
    else p_slot[1] = '{kind: PT_IX, cx: e_q.xin, cy: e_q.yin, t: e_q.tiny};
    if (inner) begin
      if (tone(tout) == CMP_LT) begin
        if (c_q[1] == CMP_LT) begin
          p_slot[2] = '{kind: PT_IY, cx: e_q.xout, cy: e_q.yout, t: e_q.toutx};
        end else begin
          p_slot[2] = '{kind: PT_IX, cx: e_q.xout, cy: e_q.yout, t: e_q.touty};
        end
      end else begin
        p_slot[2] = '{kind: PT_FIX, cx: e_q.x2, cy: e_q.y2, t: e_q.toutx};
      end
    end else if (c_q[0] == CMP_GT) begin
      p_slot[2] = '{kind: PT_FIX, cx: e_q.xin, cy: e_q.yout, t: e_q.toutx};
    end else begin
      p_slot[2] = '{kind: PT_FIX, cx: e_q.xout, cy: e_q.yin, t: e_q.toutx};
    end
  end

  assign out_free  = !ovalid_q || pt.ready;
  assign pop_o     = (state_q == S_IDLE) && valid_i;
  assign div_start = (state_q == S_DGO);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (valid_i) state_d = S_MA;
      S_MA:   state_d = S_MB;
      S_MB:   state_d = S_CMP;
      S_CMP:  state_d = (cs_q == 2'd2) ? S_PLAN : S_MA;
      S_PLAN: state_d = S_PT;
      S_PT: begin
        if (sel_q == 2'd3) state_d = S_IDLE;
        else if (!vld_q[sel_q]) state_d = S_PT;
        else if (cur.kind == PT_FIX || bypass) state_d = S_OUT;
        else state_d = S_IMUL;
      end
      S_IMUL: state_d = S_DGO;
      S_DGO:  state_d = S_DIV;
      S_DIV:  if (div_done) state_d = S_OUT;
      S_OUT:  if (out_free) state_d = S_PT;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      e_q      <= '0;
      c_q[0]   <= CMP_EQ;
      c_q[1]   <= CMP_EQ;
      c_q[2]   <= CMP_EQ;
      cs_q     <= 2'd0;
      pa_q     <= '0;
      pb_q     <= '0;
      slot_q[0] <= '0;
      slot_q[1] <= '0;
      slot_q[2] <= '0;
      vld_q    <= '0;
      sel_q    <= 2'd0;
      res_x_q  <= '0;
      res_y_q  <= '0;
      ovalid_q <= 1'b0;
      ox_q     <= '0;
      oy_q     <= '0;
      olast_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (ovalid_q && pt.ready && !((state_q == S_OUT) && out_free)) ovalid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (valid_i) begin
            e_q  <= edge_i;
            cs_q <= 2'd0;
          end
        end
        S_MA: pa_q <= prod;
        S_MB: pb_q <= prod;
        S_CMP: begin
          c_q[cs_q] <= tcmp(ca, cb, pa_q, pb_q);
          cs_q      <= cs_q + 2'd1;
        end
        S_PLAN: begin
          slot_q[0] <= p_slot[0];
          slot_q[1] <= p_slot[1];
          slot_q[2] <= p_slot[2];
          vld_q     <= p_vld;
          sel_q     <= 2'd0;
        end
        S_PT: begin
          if (sel_q != 2'd3) begin
            if (!vld_q[sel_q]) begin
              sel_q <= sel_q + 2'd1;
            end else begin
              res_x_q <= (cur.kind == PT_IX) ? e_q.x1 : cur.cx;
              res_y_q <= (cur.kind == PT_IY) ? e_q.y1 : cur.cy;
            end
          end
        end
        S_IMUL: pa_q <= prod;
        S_DIV: begin
          if (div_done) begin
            if (is_ix) res_x_q <= sum[CW-1:0];
            else res_y_q <= sum[CW-1:0];
          end
        end
        S_OUT: begin
          if (out_free) begin
            ovalid_q <= 1'b1;
            ox_q     <= res_x_q;
            oy_q     <= res_y_q;
            olast_q  <= last;
            sel_q    <= sel_q + 2'd1;
          end
        end
        default: ;
      endcase
    end
  end

  pwc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (pa_q),
    .divisor_i  (cur.t.den),
    .done_o     (div_done),
    .quo_o      (div_quo)
  );

  assign pt.valid    = ovalid_q;
  assign pt.out_x    = IO_W'(ox_q);
  assign pt.out_y    = IO_W'(oy_q);
  assign pt.run_last = olast_q;

endmodule

// File: sv/polygon_window_clipper_core.sv
// ----------------------------------------------------------------------------
// polygon_window_clipper_core
// Clips polygon edges to a rectangular window, emitting zero to three points
// per vertex.
//
//   channel   dir   handshake     payload
//   vtx_i     in    valid/ready   vert_x, vert_y, prime
//   pt_o      out   valid/ready   out_x, out_y, run_last
//   cfg       in    cfg_we_i      cfg_idx_i, cfg_data_i
//
// A priming vertex is taken by the front and never reaches the back.
// An edge is ordered and planned, then its three point slots are walked; an
// interpolated point goes through the bit-serial divider unless its delta is
// zero or its parameter is infinite.
// A two-entry queue decouples the front.
// Reset clears the window, the previous point and all control state.
// ----------------------------------------------------------------------------
module polygon_window_clipper_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  pwc_vtx_if.sink     vtx_i,
  pwc_pt_if.source    pt_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i
);
  import pwc_pkg::*;

  win_t  win_q, win_d;
  logic  fifo_push, fifo_pop, fifo_full, fifo_valid;
  edge_t fe_edge, be_edge;

  always_comb begin
    win_d = win_q;
    if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_WIN_LEFT:   win_d.left   = $signed(cfg_data_i[CW-1:0]);
        REG_WIN_BOTTOM: win_d.bottom = $signed(cfg_data_i[CW-1:0]);
        REG_WIN_RIGHT:  win_d.right  = $signed(cfg_data_i[CW-1:0]);
        REG_WIN_TOP:    win_d.top    = $signed(cfg_data_i[CW-1:0]);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0;
    end else begin
      win_q <= win_d;
    end
  end

  pwc_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vtx    (vtx_i),
    .win_i  (win_q),
    .full_i (fifo_full),
    .push_o (fifo_push),
    .edge_o (fe_edge)
  );

  pwc_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fifo_push),
    .data_i  (fe_edge),
    .pop_i   (fifo_pop),
    .full_o  (fifo_full),
    .valid_o (fifo_valid),
    .data_o  (be_edge)
  );

  pwc_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (fifo_valid),
    .edge_i  (be_edge),
    .pop_o   (fifo_pop),
    .pt      (pt_o)
  );

`ifndef NO_ASSERTIONS
  a_pop_has_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fifo_pop |-> fifo_valid)
    else $error("edge queue popped while empty");

  a_prime_no_edge: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!fifo_valid && vtx_i.valid && vtx_i.ready && vtx_i.prime) |=> !fifo_valid)
    else $error("priming vertex queued an edge");

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fifo_push |-> !fifo_full)
    else $error("edge queue overrun");
`endif

endmodule

// File: tb/sv/polygon_window_clipper_core_tb.sv
// ----------------------------------------------------------------------------
// polygon_window_clipper_core_tb
// Sends polygon vertices through the window clipper under several windows and
// compares every emitted point against a bit-exact model of the clipping rules,
// with random gaps on the vertex side and random stalls on the point side.
// ----------------------------------------------------------------------------
module polygon_window_clipper_core_tb;
  import pwc_pkg::*;

  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic               last;
  } clip_pt_t;

  // Exact edge parameter: inf is -1, 0 or +1; otherwise num/den with den > 0.
  typedef struct {
    int           inf;
    longint       num;
    longint       den;
  } edge_t_par;

  class clip_scoreboard;
    longint   wl, wb, wr, wt;
    longint   px, py;
    clip_pt_t pending[$];
    int       errors;
    int       points;
    int       edges;

    function void clear();
      wl = 0; wb = 0; wr = 0; wt = 0; px = 0; py = 0;
      pending.delete();
      errors = 0; points = 0; edges = 0;
    endfunction

    function void set_window(reg_idx_e idx, logic signed [31:0] v);
      case (idx)
        REG_WIN_LEFT:   wl = v;
        REG_WIN_BOTTOM: wb = v;
        REG_WIN_RIGHT:  wr = v;
        default:        wt = v;
      endcase
    endfunction

    function edge_t_par par_make(longint n, longint d, int sg);
      edge_t_par t;
      t.inf = 0; t.num = 0; t.den = 1;
      if (d != 0) begin
        if (d < 0) begin
          n = -n; d = -d;
        end
        t.num = n; t.den = d;
      end else if (n != 0) begin
        t.inf = ((n > 0) == (sg > 0)) ? 1 : -1;
      end
      return t;
    endfunction

    // Cross products reach 2^65, so compare in 80-bit signed arithmetic.
    function int par_cmp(edge_t_par a, edge_t_par b);
      logic signed [79:0] l, r;
      if (a.inf != 0 || b.inf != 0) return (a.inf > b.inf) - (a.inf < b.inf);
      l = 80'(a.num) * 80'(b.den);
      r = 80'(b.num) * 80'(a.den);
      return (l > r) - (l < r);
    endfunction

    function longint lerp(longint start, edge_t_par t, longint delta);
      logic [79:0] q;
      logic [79:0] mn, md;
      if (delta == 0 || t.inf != 0) return start;
      mn = (t.num < 0) ? 80'(-t.num) : 80'(t.num);
      md = (delta < 0) ? 80'(-delta) : 80'(delta);
      q = (mn * md) / 80'(t.den);
      if ((t.num < 0) != (delta < 0) && t.num != 0) return start - longint'(q);
      return start + longint'(q);
    endfunction

    function void push(longint x, longint y);
      clip_pt_t p;
      p.x = x[31:0]; p.y = y[31:0]; p.last = 1'b0;
      pending.push_back(p);
    endfunction

    function void note_vertex(logic signed [31:0] vx, logic signed [31:0] vy, logic pr);
      longint x1, y1, x2, y2, dx, dy, xi, xo, yi, yo;
      int sgx, sgy, base;
      edge_t_par tix, tiy, t1, t2, tox, toy, tout, zero, one;
      x1 = px; y1 = py; x2 = vx; y2 = vy;
      px = x2; py = y2;
      if (pr) return;
      edges++;
      zero = '{0, 0, 1}; one = '{0, 1, 1};
      base = pending.size();
      dx = x2 - x1; dy = y2 - y1;
      sgx = dx > 0 ? 1 : (dx < 0 ? -1 : (x1 > wl ? -1 : 1));
      sgy = dy > 0 ? 1 : (dy < 0 ? -1 : (y1 > wb ? -1 : 1));
      if (sgx > 0) begin xi = wl; xo = wr; end else begin xi = wr; xo = wl; end
      if (sgy > 0) begin yi = wb; yo = wt; end else begin yi = wt; yo = wb; end
      tix = par_make(xi - x1, dx, sgx);
      tiy = par_make(yi - y1, dy, sgy);
      if (par_cmp(tix, tiy) < 0) begin t1 = tix; t2 = tiy; end
      else begin t1 = tiy; t2 = tix; end
      if (par_cmp(t1, one) <= 0) begin
        if (par_cmp(t1, zero) > 0) push(xi, yi);
        if (par_cmp(t2, one) <= 0) begin
          tox = par_make(xo - x1, dx, sgx);
          toy = par_make(yo - y1, dy, sgy);
          tout = par_cmp(tox, toy) < 0 ? tox : toy;
          if (par_cmp(t2, zero) > 0 || par_cmp(tout, zero) > 0) begin
            if (par_cmp(t2, tout) <= 0) begin
              if (par_cmp(t2, zero) > 0) begin
                if (par_cmp(tix, tiy) > 0) push(xi, lerp(y1, tix, dy));
                else push(lerp(x1, tiy, dx), yi);
              end
              if (par_cmp(tout, one) < 0) begin
                if (par_cmp(tox, toy) < 0) push(xo, lerp(y1, tox, dy));
                else push(lerp(x1, toy, dx), yo);
              end else begin
                push(x2, y2);
              end
            end else begin
              if (par_cmp(tix, tiy) > 0) push(xi, yo);
              else push(xo, yi);
            end
          end
        end
      end
      if (pending.size() > base) pending[pending.size()-1].last = 1'b1;
    endfunction

    function void check_point(logic signed [31:0] x, logic signed [31:0] y, logic l);
      clip_pt_t e;
      points++;
      if (pending.size() == 0) begin
        $display("%0t: unexpected point x=%0d y=%0d last=%0b", $time, x, y, l);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (x !== e.x || y !== e.y || l !== e.last) begin
        $display("%0t: point mismatch exp x=%0d y=%0d last=%0b act x=%0d y=%0d last=%0b",
                 $time, e.x, e.y, e.last, x, y, l);
        errors++;
      end
    endfunction
  endclass

  localparam int CYCLE_LIMIT = 400000;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [31:0] cfg_data_i;
  longint      cycles;

  pwc_vtx_if vtx ();
  pwc_pt_if  pt ();

  clip_scoreboard sb;

  polygon_window_clipper_core dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .vtx_i     (vtx.sink),
    .pt_o      (pt.source),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("polygon_window_clipper_core_tb: FAIL");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && vtx.valid && vtx.ready) sb.note_vertex(vtx.vert_x, vtx.vert_y, vtx.prime);
    if (rst_ni && pt.valid && pt.ready) sb.check_point(pt.out_x, pt.out_y, pt.run_last);
  end

  // Point side: random stalls, with stretches of none.
  initial begin : pt_stall
    int w;
    pt.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
      if (w > 0) begin
        pt.ready <= 1'b0;
        repeat (w) @(negedge clk_i);
      end
      pt.ready <= 1'b1;
      do @(posedge clk_i); while (!pt.valid);
    end
  end

  task automatic write_reg(reg_idx_e idx, logic signed [31:0] v);
    @(negedge clk_i);
    cfg_we_i <= 1'b1; cfg_idx_i <= idx; cfg_data_i <= v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_window(idx, v);
  endtask

  task automatic set_window(logic signed [31:0] l, logic signed [31:0] b,
                            logic signed [31:0] r, logic signed [31:0] t);
    write_reg(REG_WIN_LEFT, l);
    write_reg(REG_WIN_BOTTOM, b);
    write_reg(REG_WIN_RIGHT, r);
    write_reg(REG_WIN_TOP, t);
  endtask

  task automatic send_vertex(logic signed [31:0] x, logic signed [31:0] y, logic pr,
                             bit gaps);
    int w;
    w = gaps ? (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12)) : 0;
    if (w > 0) begin
      vtx.valid <= 1'b0;
      repeat (w) @(negedge clk_i);
    end
    vtx.valid <= 1'b1; vtx.vert_x <= x; vtx.vert_y <= y; vtx.prime <= pr;
    do @(posedge clk_i); while (!vtx.ready);
    @(negedge clk_i);
  endtask

  task automatic drain();
    vtx.valid <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk_i);
    repeat (200) @(negedge clk_i);
  endtask

  function automatic logic signed [31:0] rand_coord(int mode,
                                                     logic signed [31:0] lo,
                                                     logic signed [31:0] hi);
    longint a, b;
    case (mode)
      0: return $urandom();
      1: return $signed($urandom_range(0, 400)) - 200;
      default: begin
        a = lo - 20; b = hi + 20;
        if (b < a) begin a = hi - 20; b = lo + 20; end
        return 32'(a + longint'($urandom_range(0, 32'(b - a))));
      end
    endcase
  endfunction

  task automatic random_polygons(int count, int mode,
                                 logic signed [31:0] l, logic signed [31:0] b,
                                 logic signed [31:0] r, logic signed [31:0] t);
    int sent;
    int nv;
    logic signed [31:0] vx, vy;
    sent = 0;
    while (sent < count) begin
      nv = $urandom_range(3, 7);
      vx = rand_coord(mode, l, r); vy = rand_coord(mode, b, t);
      send_vertex(vx, vy, 1'b1, 1'b1);
      repeat (nv) begin
        // sometimes repeat a coordinate to hit a zero delta
        if ($urandom_range(0, 5) != 0) vx = rand_coord(mode, l, r);
        if ($urandom_range(0, 5) != 0) vy = rand_coord(mode, b, t);
        send_vertex(vx, vy, ($urandom_range(0, 19) == 0), ($urandom_range(0, 4) != 0));
        sent++;
      end
    end
  endtask

  initial begin
    sb = new();
    sb.clear();
    cycles = 0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0; cfg_idx_i = '0; cfg_data_i = '0;
    vtx.valid = 1'b0; vtx.vert_x = '0; vtx.vert_y = '0; vtx.prime = 1'b0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // edge before priming, default zero window
    send_vertex(32'sd5, 32'sd5, 1'b0, 1'b0);
    send_vertex(32'sd0, 32'sd0, 1'b0, 1'b0);
    drain();

    set_window(-32'sd100, -32'sd50, 32'sd100, 32'sd50);
    send_vertex(-32'sd200, 32'sd0, 1'b1, 1'b0);
    send_vertex(32'sd200, 32'sd0, 1'b0, 1'b0);
    send_vertex(32'sd200, 32'sd0, 1'b0, 1'b0);
    send_vertex(32'sd0, 32'sd0, 1'b0, 1'b0);
    send_vertex(32'sd10, 32'sd20, 1'b0, 1'b0);
    send_vertex(-32'sd300, 32'sd300, 1'b0, 1'b0);
    send_vertex(32'sd300, -32'sd300, 1'b0, 1'b0);
    send_vertex(32'sd300, 32'sd300, 1'b0, 1'b0);
    send_vertex(32'sh7fffffff, 32'sh80000000, 1'b0, 1'b0);
    send_vertex(32'sh80000000, 32'sh7fffffff, 1'b0, 1'b0);
    send_vertex(32'sh80000000, 32'sh80000000, 1'b0, 1'b0);
    send_vertex(32'sh7fffffff, 32'sh7fffffff, 1'b0, 1'b0);
    send_vertex(32'sd100, 32'sd50, 1'b0, 1'b0);
    send_vertex(32'sd40, -32'sd7, 1'b1, 1'b0);
    send_vertex(32'sd40, -32'sd7, 1'b0, 1'b0);
    drain();

    // inverted window
    set_window(32'sd30, 32'sd30, -32'sd30, -32'sd30);
    send_vertex(-32'sd60, -32'sd40, 1'b1, 1'b0);
    send_vertex(32'sd60, 32'sd45, 1'b0, 1'b0);
    send_vertex(32'sd0, -32'sd70, 1'b0, 1'b0);
    drain();

    // extreme window
    set_window(32'sh80000000, 32'sh80000000, 32'sh7fffffff, 32'sh7fffffff);
    random_polygons(12, 0, 0, 0, 0, 0);
    drain();

    set_window(-32'sd100, -32'sd80, 32'sd120, 32'sd90);
    random_polygons(25, 2, -32'sd100, -32'sd80, 32'sd120, 32'sd90);
    drain();

    set_window(-32'sd1000000, 32'sd5, 32'sd1000000, 32'sd5);
    random_polygons(12, 1, 0, 0, 0, 0);
    drain();

    set_window(-32'sd2000000000, -32'sd1500000000, 32'sd1800000000, 32'sd2100000000);
    random_polygons(14, 0, 0, 0, 0, 0);
    drain();

    $display("Covered %0d edges and %0d clipped points over seven window settings,",
             sb.edges, sb.points);
    $display("including inverted, degenerate and full-range windows.");
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("polygon_window_clipper_core_tb: PASS");
    end else begin
      $display("polygon_window_clipper_core_tb: FAIL");
    end
    $finish;
  end
endmodule

// File: polygon_window_clipper_core.f
sv/pwc_pkg.sv
sv/pwc_vtx_if.sv
sv/pwc_pt_if.sv
sv/pwc_front.sv
sv/pwc_fifo.sv
sv/pwc_div.sv
sv/pwc_back.sv
sv/polygon_window_clipper_core.sv
tb/sv/polygon_window_clipper_core_tb.sv
